// ===== rtl/cht_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the hash table unit.
`timescale 1ns / 1ps

package cht_pkg;

    // Table geometry
    localparam int BUCKETS = 1024;
    localparam int ENTRIES = 4096;

    // Field widths
    localparam int KEY_W   = 31;
    localparam int IDX_W   = 13;
    localparam int CFG_W   = 11;
    localparam int FUNC_W  = 2;

    // Derived widths
    localparam int BKT_AW  = $clog2(BUCKETS);
    localparam int N_W     = BKT_AW + 1;
    localparam int ENT_AW  = $clog2(ENTRIES);
    localparam int STEP_W  = $clog2(ENTRIES + 1);
    localparam int BIT_W   = $clog2(KEY_W);
    localparam int EKEY_W  = KEY_W + 1;

    // Stream packing
    localparam int IN_DATA_W  = ((KEY_W + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((1 + IDX_W + 7) / 8) * 8;

    // Removed mark in the key store: all ones never equals a stored key
    localparam logic [EKEY_W-1:0] REMOVED_KEY = '1;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // Which value the pending result takes
    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_PUT  = 2'd1,
        RES_HIT  = 2'd2
    } t_res_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      start;
        logic      clr_wr;
        logic      mod_step;
        logic      head_rd;
        logic      head_wr_put;
        logic      ent_wr_put;
        logic      key_rm;
        logic      cur_from_head;
        logic      ent_rd;
        logic      cur_from_link;
        logic      res_set;
        t_res_kind res_kind;
        logic      res_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_func func;
        logic  slot_ok;
        logic  clr_last;
        logic  mod_done;
        logic  cur_ok;
        logic  steps_max;
        logic  key_match;
        logic  out_free;
    } t_sts;

endpackage

// ===== rtl/cht_dpath.sv =====
// Datapath of the hash table unit: registers, modulo unit, bucket and entry memories.
`timescale 1ns / 1ps

module cht_dpath
    import cht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    // tdata: key [30:0], slot [43:31], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func [1:0]
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: found [0], match_index [13:1], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    // Request registers
    t_func              r_func;
    logic [KEY_W-1:0]   r_key;
    logic [IDX_W-1:0]   r_slot;

    // Modulo unit
    logic [N_W-1:0]     r_n;
    logic [BKT_AW-1:0]  r_rem;
    logic [KEY_W-1:0]   r_div_sh;
    logic [BIT_W-1:0]   r_bit_cnt;
    logic [N_W-1:0]     trial;
    logic [N_W-1:0]     trial_sub;
    logic [N_W-1:0]     n_eff;

    // Configuration
    logic [CFG_W-1:0]   r_bucket_count;

    // Chain walk
    logic [IDX_W-1:0]   r_cur;
    logic [STEP_W-1:0]  r_steps;
    logic [BKT_AW-1:0]  r_clr_addr;

    // Memories and their registered read data
    logic [IDX_W-1:0]   r_head_mem [BUCKETS];
    logic [EKEY_W-1:0]  r_key_mem  [ENTRIES];
    logic [IDX_W-1:0]   r_link_mem [ENTRIES];
    logic [IDX_W-1:0]   r_head_q;
    logic [EKEY_W-1:0]  r_ent_key_q;
    logic [IDX_W-1:0]   r_ent_link_q;

    // Pending and output results
    logic               r_res_found;
    logic [IDX_W-1:0]   r_res_idx;
    logic               r_out_valid;
    logic               r_out_found;
    logic [IDX_W-1:0]   r_out_idx;

    logic [IDX_W-1:0]   slot_m1;
    logic [IDX_W-1:0]   cur_m1;
    logic [ENT_AW-1:0]  ent_wr_addr;
    logic [EKEY_W-1:0]  ent_wr_key;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CFG_W'(BUCKETS);
        end else if (i_cfg_valid) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    // Bucket count in use: zero acts as one, anything above the table size as the table size
    always_comb begin
        if (r_bucket_count == '0) begin
            n_eff = N_W'(1);
        end else if (r_bucket_count > CFG_W'(BUCKETS)) begin
            n_eff = N_W'(BUCKETS);
        end else begin
            n_eff = N_W'(r_bucket_count);
        end
    end

    // Restoring remainder step, one key bit per cycle from the top
    assign trial     = {r_rem, r_div_sh[KEY_W-1]};
    assign trial_sub = trial - r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= N_W'(1);
            r_rem     <= '0;
            r_bit_cnt <= '0;
        end else if (i_cmd.start) begin
            r_n       <= n_eff;
            r_rem     <= '0;
            r_bit_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem     <= (trial >= r_n) ? trial_sub[BKT_AW-1:0] : trial[BKT_AW-1:0];
            r_bit_cnt <= r_bit_cnt + BIT_W'(1);
        end
    end

    // Request capture and the dividend shift line
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_func   <= t_func'(s_axis_tuser);
            r_key    <= s_axis_tdata[KEY_W-1:0];
            r_slot   <= s_axis_tdata[KEY_W +: IDX_W];
            r_div_sh <= s_axis_tdata[KEY_W-1:0];
        end else if (i_cmd.mod_step) begin
            r_div_sh <= {r_div_sh[KEY_W-2:0], 1'b0};
        end
    end

    // Clearing sweep address, used after reset and by the clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + BKT_AW'(1);
        end
    end

    // Bucket head memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_head_mem[r_clr_addr] <= '0;
        end else if (i_cmd.head_wr_put) begin
            r_head_mem[r_rem] <= r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_rd) begin
            r_head_q <= r_head_mem[r_rem];
        end
    end

    // Entry store: slot numbers from one upward map to addresses from zero
    assign slot_m1     = r_slot - IDX_W'(1);
    assign cur_m1      = r_cur - IDX_W'(1);
    assign ent_wr_addr = i_cmd.key_rm ? cur_m1[ENT_AW-1:0] : slot_m1[ENT_AW-1:0];
    assign ent_wr_key  = i_cmd.key_rm ? REMOVED_KEY : {1'b0, r_key};

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_wr_put || i_cmd.key_rm) begin
            r_key_mem[ent_wr_addr] <= ent_wr_key;
        end
        if (i_cmd.ent_wr_put) begin
            r_link_mem[ent_wr_addr] <= r_head_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_rd) begin
            r_ent_key_q  <= r_key_mem[cur_m1[ENT_AW-1:0]];
            r_ent_link_q <= r_link_mem[cur_m1[ENT_AW-1:0]];
        end
    end

    // Chain cursor and step count
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_from_head) begin
            r_cur   <= r_head_q;
            r_steps <= '0;
        end else if (i_cmd.cur_from_link) begin
            r_cur   <= r_ent_link_q;
            r_steps <= r_steps + STEP_W'(1);
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_kind)
                RES_PUT: begin
                    r_res_found <= 1'b0;
                    r_res_idx   <= r_slot;
                end
                RES_HIT: begin
                    r_res_found <= 1'b1;
                    r_res_idx   <= r_cur;
                end
                default: begin
                    r_res_found <= 1'b0;
                    r_res_idx   <= '0;
                end
            endcase
        end
    end

    // Output register, parts the result side from the request side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - 1 - IDX_W)'(0), r_out_idx, r_out_found};

    // Status to the controller
    assign o_sts.func      = r_func;
    assign o_sts.slot_ok   = (r_slot != '0) && (r_slot <= IDX_W'(ENTRIES));
    assign o_sts.clr_last  = (r_clr_addr == BKT_AW'(BUCKETS - 1));
    assign o_sts.mod_done  = (r_bit_cnt == BIT_W'(KEY_W - 1));
    assign o_sts.cur_ok    = (r_cur != '0) && (r_cur <= IDX_W'(ENTRIES));
    assign o_sts.steps_max = (r_steps >= STEP_W'(ENTRIES));
    assign o_sts.key_match = (r_ent_key_q == {1'b0, r_key});
    assign o_sts.out_free  = !r_out_valid || m_axis_tready;

    // The remainder always stays below the bucket count in use
    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rem} < r_n)
        else $error("bucket remainder not below bucket count");

    // A result is never loaded over one that has not been taken
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_valid || m_axis_tready))
        else $error("result register overwritten");

    // A hit always reports a real slot
    a_hit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_set && i_cmd.res_kind == RES_HIT) |-> o_sts.cur_ok)
        else $error("hit reported on an empty link");

endmodule

// ===== rtl/cht_ctrl.sv =====
// Controller of the hash table unit: sequences clearing, modulo, head access and chain walk.
`timescale 1ns / 1ps

module cht_ctrl
    import cht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    input  logic s_axis_tvalid,
    output logic s_axis_tready
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_MOD,
        S_HEAD,
        S_HEAD_W,
        S_WALK,
        S_CHECK,
        S_DONE
    } t_state;

    t_state r_state;

    assign s_axis_tready = (r_state == S_IDLE);

    // Command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.res_kind = RES_ZERO;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
            end
            S_IDLE: begin
                o_cmd.start = s_axis_tvalid;
            end
            S_DISPATCH: begin
                if (i_sts.func == FUNC_PUT && !i_sts.slot_ok) begin
                    o_cmd.res_set = 1'b1;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.res_set = i_sts.clr_last;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_HEAD: begin
                o_cmd.head_rd = 1'b1;
            end
            S_HEAD_W: begin
                if (i_sts.func == FUNC_PUT) begin
                    o_cmd.ent_wr_put  = 1'b1;
                    o_cmd.head_wr_put = 1'b1;
                    o_cmd.res_set     = 1'b1;
                    o_cmd.res_kind    = RES_PUT;
                end else begin
                    o_cmd.cur_from_head = 1'b1;
                end
            end
            S_WALK: begin
                if (!i_sts.cur_ok || i_sts.steps_max) begin
                    o_cmd.res_set = 1'b1;
                end else begin
                    o_cmd.ent_rd = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.key_match) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RES_HIT;
                    o_cmd.key_rm   = (i_sts.func == FUNC_REMOVE);
                end else begin
                    o_cmd.cur_from_link = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.res_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    if (i_sts.func == FUNC_CLEAR) begin
                        r_state <= S_CLEAR;
                    end else if (i_sts.func == FUNC_PUT && !i_sts.slot_ok) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_DONE;
                end
                S_MOD: begin
                    if (i_sts.mod_done) r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_state <= S_HEAD_W;
                end
                S_HEAD_W: begin
                    r_state <= (i_sts.func == FUNC_PUT) ? S_DONE : S_WALK;
                end
                S_WALK: begin
                    if (!i_sts.cur_ok || i_sts.steps_max) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= i_sts.key_match ? S_DONE : S_WALK;
                end
                S_DONE: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted request is always dispatched on the next cycle
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");

    // The head memory never sees two writers at once
    a_one_head_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.clr_wr && o_cmd.head_wr_put))
        else $error("clearing sweep and put write the head memory together");

    // The clearing sweep after reset is never left before its last bucket head is written
    a_init_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && !i_sts.clr_last) |=> (r_state == S_INIT))
        else $error("clearing sweep left early");

endmodule

// ===== rtl/chained_hash_table_unit.sv =====
// Sequence: a put runs dispatch, the remainder steps, the head read and the head and entry write; a put
// with a bad slot ends at dispatch; get and remove also walk the chain, a read and a key check per entry.
// Throughput: one request at a time; the remainder unit and the chain walk hold off the next request.
// Clear: one bucket head written per cycle through the head memory port.
// Reset: synchronous, active low; a sweep then zeroes the bucket heads, with no
// request taken meanwhile (configuration writes are taken). Entry keys and links are not cleared.
`timescale 1ns / 1ps

module chained_hash_table_unit
    import cht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: key [30:0], slot [43:31], zero fill above
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: func [1:0]
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: found [0], match_index [13:1], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // Controller
    cht_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready)
    );

    // Datapath
    cht_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

endmodule
